FILE: rtl/core/hsme_pkg.sv
// shared types and constants of the hierarchical state machine engine
`timescale 1ns / 1ps
package hsme_pkg;

    // fixed table geometry
    localparam int NUM_STATES      = 16;
    localparam int TRANS_PER_STATE = 4;
    localparam int EVENT_BITS      = 8;
    localparam int ST_W            = $clog2(NUM_STATES);
    localparam int SLOT_W          = $clog2(TRANS_PER_STATE);
    localparam int CNT_W           = 3;

    // transition flag bit positions
    localparam int TF_INTERNAL = 0;
    localparam int TF_GUARD    = 1;
    localparam int TF_ACTION   = 2;

    // commands
    localparam logic [2:0] CMD_LOAD_STATE = 3'd0;
    localparam logic [2:0] CMD_LOAD_TRANS = 3'd1;
    localparam logic [2:0] CMD_INIT       = 3'd2;
    localparam logic [2:0] CMD_DISPATCH   = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACTION = 2'd0;
    localparam logic [1:0] KIND_EXIT   = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // datapath operations
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_ACCEPT    = 5'd1;
    localparam logic [4:0] OP_QCMP      = 5'd2;
    localparam logic [4:0] OP_UP_RD     = 5'd3;
    localparam logic [4:0] OP_DST       = 5'd4;
    localparam logic [4:0] OP_TAKE      = 5'd5;
    localparam logic [4:0] OP_NEXT_SLOT = 5'd6;
    localparam logic [4:0] OP_UP_REG    = 5'd7;
    localparam logic [4:0] OP_EMIT_ACT  = 5'd8;
    localparam logic [4:0] OP_GSTART    = 5'd9;
    localparam logic [4:0] OP_SLATCH    = 5'd10;
    localparam logic [4:0] OP_EMIT_SX   = 5'd11;
    localparam logic [4:0] OP_EMIT_SN   = 5'd12;
    localparam logic [4:0] OP_ARD       = 5'd13;
    localparam logic [4:0] OP_ACHK      = 5'd14;
    localparam logic [4:0] OP_BRD       = 5'd15;
    localparam logic [4:0] OP_BCHK      = 5'd16;
    localparam logic [4:0] OP_ALN       = 5'd17;
    localparam logic [4:0] OP_CMP_STEP  = 5'd18;
    localparam logic [4:0] OP_CMP_END   = 5'd19;
    localparam logic [4:0] OP_XEMIT     = 5'd20;
    localparam logic [4:0] OP_NDEC      = 5'd21;
    localparam logic [4:0] OP_NEMIT     = 5'd22;
    localparam logic [4:0] OP_COMMIT    = 5'd23;
    localparam logic [4:0] OP_FIN       = 5'd24;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  state_index;
        logic [3:0]  link_index;
        logic [2:0]  flags;
        logic [2:0]  trans_count;
        logic [1:0]  trans_slot;
        logic [7:0]  event_id;
        logic [63:0] guard_results;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] state_id;
        logic [1:0] action_slot;
        logic       answer;
        logic       last;
    } t_out;

    // state table entry
    typedef struct packed {
        logic             has_parent;
        logic [ST_W-1:0]  parent;
        logic             entry_f;
        logic             exit_f;
        logic [CNT_W-1:0] cnt;
    } t_sent;

    // transition table entry
    typedef struct packed {
        logic [EVENT_BITS-1:0] ev;
        logic [ST_W-1:0]       target;
        logic [2:0]            flags;
    } t_tent;

    typedef struct packed {
        logic [4:0] op;
    } t_ctl;

    typedef struct packed {
        logic out_free;
        logic cur_valid;
        logic is_self;
        logic cnt_zero;
        logic up_rd;
        logic up_reg;
        logic tr_match;
        logic tr_act;
        logic tr_int;
        logic tfl_int;
        logic more_slots;
        logic cmp_go;
        logic x_done;
        logic x_flag;
        logic n_done;
        logic n_flag;
        logic s_exit;
        logic s_entry;
    } t_status;

endpackage

FILE: rtl/core/hsme_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module hsme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/hsme_ctrl.sv
// controller state machine of the hierarchical state machine engine
`timescale 1ns / 1ps
module hsme_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0]       i_cmd,
    input  hsme_pkg::t_status i_status,
    output hsme_pkg::t_ctl   o_ctl,
    output logic             o_busy
);
    import hsme_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_QRD   = 5'd1;
    localparam logic [4:0] S_QCHK  = 5'd2;
    localparam logic [4:0] S_DRD   = 5'd3;
    localparam logic [4:0] S_DST   = 5'd4;
    localparam logic [4:0] S_DTW   = 5'd5;
    localparam logic [4:0] S_DTR   = 5'd6;
    localparam logic [4:0] S_DACT  = 5'd7;
    localparam logic [4:0] S_GOTO  = 5'd8;
    localparam logic [4:0] S_SRD   = 5'd9;
    localparam logic [4:0] S_SCHK  = 5'd10;
    localparam logic [4:0] S_SEX   = 5'd11;
    localparam logic [4:0] S_SEN   = 5'd12;
    localparam logic [4:0] S_ARD   = 5'd13;
    localparam logic [4:0] S_ACHK  = 5'd14;
    localparam logic [4:0] S_BRD   = 5'd15;
    localparam logic [4:0] S_BCHK  = 5'd16;
    localparam logic [4:0] S_ALN   = 5'd17;
    localparam logic [4:0] S_CMP   = 5'd18;
    localparam logic [4:0] S_XEMIT = 5'd19;
    localparam logic [4:0] S_NCHK  = 5'd20;
    localparam logic [4:0] S_NEMIT = 5'd21;
    localparam logic [4:0] S_FIN   = 5'd22;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [4:0] n_op;

    // next state and datapath operation
    always_comb begin
        n_state = r_state;
        n_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = OP_ACCEPT;
                    case (i_cmd)
                        CMD_INIT:     n_state = S_GOTO;
                        CMD_DISPATCH: n_state = i_status.cur_valid ? S_DRD : S_FIN;
                        CMD_QUERY:    n_state = i_status.cur_valid ? S_QRD : S_FIN;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_QRD: begin
                n_op    = OP_QCMP;
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (i_status.up_rd) begin
                    n_op    = OP_UP_RD;
                    n_state = S_QRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DRD: n_state = S_DST;
            S_DST: begin
                if (!i_status.cnt_zero) begin
                    n_op    = OP_DST;
                    n_state = S_DTW;
                end else if (i_status.up_rd) begin
                    n_op    = OP_UP_RD;
                    n_state = S_DRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DTW: n_state = S_DTR;
            S_DTR: begin
                if (i_status.tr_match) begin
                    n_op = OP_TAKE;
                    if (i_status.tr_act) begin
                        n_state = S_DACT;
                    end else begin
                        n_state = i_status.tr_int ? S_FIN : S_GOTO;
                    end
                end else if (i_status.more_slots) begin
                    n_op    = OP_NEXT_SLOT;
                    n_state = S_DTW;
                end else if (i_status.up_reg) begin
                    n_op    = OP_UP_REG;
                    n_state = S_DRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DACT: begin
                if (i_status.out_free) begin
                    n_op    = OP_EMIT_ACT;
                    n_state = i_status.tfl_int ? S_FIN : S_GOTO;
                end
            end
            S_GOTO: begin
                n_op = OP_GSTART;
                if (i_status.is_self) begin
                    n_state = S_SRD;
                end else begin
                    n_state = i_status.cur_valid ? S_ARD : S_BRD;
                end
            end
            S_SRD:  n_state = S_SCHK;
            S_SCHK: begin
                n_op    = OP_SLATCH;
                n_state = S_SEX;
            end
            S_SEX: begin
                if (!i_status.s_exit || i_status.out_free) begin
                    n_op    = OP_EMIT_SX;
                    n_state = S_SEN;
                end
            end
            S_SEN: begin
                if (!i_status.s_entry || i_status.out_free) begin
                    n_op    = OP_EMIT_SN;
                    n_state = S_FIN;
                end
            end
            S_ARD: begin
                n_op    = OP_ARD;
                n_state = S_ACHK;
            end
            S_ACHK: begin
                n_op    = OP_ACHK;
                n_state = i_status.up_rd ? S_ARD : S_BRD;
            end
            S_BRD: begin
                n_op    = OP_BRD;
                n_state = S_BCHK;
            end
            S_BCHK: begin
                n_op    = OP_BCHK;
                n_state = i_status.up_rd ? S_BRD : S_ALN;
            end
            S_ALN: begin
                n_op    = OP_ALN;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_status.cmp_go) begin
                    n_op = OP_CMP_STEP;
                end else begin
                    n_op    = OP_CMP_END;
                    n_state = S_XEMIT;
                end
            end
            S_XEMIT: begin
                if (i_status.x_done) begin
                    n_state = S_NCHK;
                end else if (!i_status.x_flag || i_status.out_free) begin
                    n_op = OP_XEMIT;
                end
            end
            S_NCHK: begin
                if (i_status.n_done) begin
                    n_op    = OP_COMMIT;
                    n_state = S_FIN;
                end else begin
                    n_op    = OP_NDEC;
                    n_state = S_NEMIT;
                end
            end
            S_NEMIT: begin
                if (!i_status.n_flag || i_status.out_free) begin
                    n_op    = OP_NEMIT;
                    n_state = S_NCHK;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    n_op    = OP_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl.op = n_op;
    assign o_busy   = (r_state != S_IDLE);
endmodule

FILE: rtl/core/hsme_dp.sv
// datapath: tables, ancestor chains, counters and output register
`timescale 1ns / 1ps
module hsme_dp #(
    parameter int MAX_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsme_pkg::t_in     i_item,
    input  hsme_pkg::t_ctl    i_ctl,
    input  logic              i_stall,
    output hsme_pkg::t_status o_status,
    output logic              o_valid,
    output hsme_pkg::t_out    o_item
);
    import hsme_pkg::*;

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int IW = $clog2(MAX_DEPTH);

    // latched transaction and walk registers
    t_in                         r_item;
    logic [ST_W-1:0]             r_cur;
    logic                        r_cur_valid;
    logic [ST_W-1:0]             r_walk;
    logic [CW-1:0]               r_depth;
    logic [SLOT_W-1:0]           r_slot;
    logic                        r_ans;
    logic [ST_W-1:0]             r_target;
    logic [2:0]                  r_tfl;
    t_sent                       r_ent;
    logic                        r_sx;
    logic                        r_sn;
    // source and target ancestor chains
    logic [ST_W-1:0]             r_src [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]        r_src_x;
    logic [ST_W-1:0]             r_ep [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]        r_ep_n;
    logic [CW-1:0]               r_da;
    logic [CW-1:0]               r_db;
    logic [CW-1:0]               r_ia;
    logic [CW-1:0]               r_ib;
    logic [CW-1:0]               r_lim;
    logic                        r_ov;
    t_out                        r_out;

    logic                        accept;
    logic                        st_we;
    logic                        tr_we;
    t_sent                       st_wdata;
    t_tent                       tr_wdata;
    logic [$bits(t_sent)-1:0]    st_rdata;
    logic [$bits(t_tent)-1:0]    tr_rdata;
    t_sent                       srd;
    t_tent                       trd;
    logic [IW-1:0]               ia_idx;
    logic [IW-1:0]               ib_idx;
    logic [IW-1:0]               d_idx;
    logic                        depth_ok;
    logic                        out_free;
    logic                        emit_en;
    t_out                        n_out;
    logic [CNT_W-1:0]            sat_cnt;

    assign accept   = (i_ctl.op == OP_ACCEPT);
    assign ia_idx   = r_ia[IW-1:0];
    assign ib_idx   = r_ib[IW-1:0];
    assign d_idx    = r_depth[IW-1:0];
    assign depth_ok = (r_depth + CW'(1)) < CW'(MAX_DEPTH);
    assign out_free = !r_ov || !i_stall;

    // table writes from load transactions
    assign sat_cnt  = (i_item.trans_count > CNT_W'(TRANS_PER_STATE)) ?
                      CNT_W'(TRANS_PER_STATE) : i_item.trans_count;
    assign st_we    = accept && (i_item.command == CMD_LOAD_STATE);
    assign tr_we    = accept && (i_item.command == CMD_LOAD_TRANS);
    assign st_wdata = '{has_parent: i_item.flags[0],
                        parent:     i_item.flags[0] ? i_item.link_index : '0,
                        entry_f:    i_item.flags[1],
                        exit_f:     i_item.flags[2],
                        cnt:        sat_cnt};
    assign tr_wdata = '{ev: i_item.event_id, target: i_item.link_index,
                        flags: i_item.flags};

    hsme_ram #(.WIDTH($bits(t_sent)), .DEPTH(NUM_STATES)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (i_item.state_index),
        .i_wdata (st_wdata),
        .i_raddr (r_walk),
        .o_rdata (st_rdata)
    );

    hsme_ram #(.WIDTH($bits(t_tent)), .DEPTH(NUM_STATES * TRANS_PER_STATE)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr ({i_item.state_index, i_item.trans_slot}),
        .i_wdata (tr_wdata),
        .i_raddr ({r_walk, r_slot}),
        .o_rdata (tr_rdata)
    );

    assign srd = t_sent'(st_rdata);
    assign trd = t_tent'(tr_rdata);

    // status toward the controller
    always_comb begin
        o_status.out_free   = out_free;
        o_status.cur_valid  = r_cur_valid;
        o_status.is_self    = r_cur_valid && (r_cur == r_target);
        o_status.cnt_zero   = (srd.cnt == '0);
        o_status.up_rd      = srd.has_parent && depth_ok;
        o_status.up_reg     = r_ent.has_parent && depth_ok;
        o_status.tr_match   = (trd.ev == r_item.event_id) &&
                              (!trd.flags[TF_GUARD] ||
                               r_item.guard_results[{r_walk, r_slot}]);
        o_status.tr_act     = trd.flags[TF_ACTION];
        o_status.tr_int     = trd.flags[TF_INTERNAL];
        o_status.tfl_int    = r_tfl[TF_INTERNAL];
        o_status.more_slots = ({1'b0, r_slot} + CNT_W'(1)) < r_ent.cnt;
        o_status.cmp_go     = (r_ia < r_da) && (r_ib < r_db) &&
                              (r_src[ia_idx] != r_ep[ib_idx]);
        o_status.x_done     = (r_ia == r_lim);
        o_status.x_flag     = r_src_x[ia_idx];
        o_status.n_done     = (r_ib == '0);
        o_status.n_flag     = r_ep_n[ib_idx];
        o_status.s_exit     = r_sx;
        o_status.s_entry    = r_sn;
    end

    // result item selection
    always_comb begin
        n_out   = '0;
        emit_en = 1'b0;
        case (i_ctl.op)
            OP_EMIT_ACT: begin
                n_out.kind        = KIND_ACTION;
                n_out.state_id    = r_walk;
                n_out.action_slot = r_slot;
                emit_en           = 1'b1;
            end
            OP_XEMIT: begin
                n_out.kind     = KIND_EXIT;
                n_out.state_id = r_src[ia_idx];
                emit_en        = r_src_x[ia_idx];
            end
            OP_NEMIT: begin
                n_out.kind     = KIND_ENTRY;
                n_out.state_id = r_ep[ib_idx];
                emit_en        = r_ep_n[ib_idx];
            end
            OP_EMIT_SX: begin
                n_out.kind     = KIND_EXIT;
                n_out.state_id = r_target;
                emit_en        = r_sx;
            end
            OP_EMIT_SN: begin
                n_out.kind     = KIND_ENTRY;
                n_out.state_id = r_target;
                emit_en        = r_sn;
            end
            OP_FIN: begin
                n_out.kind     = KIND_DONE;
                n_out.state_id = r_cur_valid ? r_cur : '0;
                n_out.answer   = r_ans;
                n_out.last     = 1'b1;
                emit_en        = 1'b1;
            end
            default: emit_en = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_ov        <= 1'b0;
            r_da        <= '0;
            r_db        <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_lim       <= '0;
        end else begin
            if (emit_en) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            case (i_ctl.op)
                OP_ACCEPT: begin
                    if (i_item.command == CMD_INIT) begin
                        r_cur_valid <= 1'b0;
                        r_cur       <= '0;
                    end
                end
                OP_GSTART: begin
                    r_da <= '0;
                    r_db <= '0;
                    r_ia <= '0;
                    r_ib <= '0;
                end
                OP_ACHK: r_da <= r_depth + CW'(1);
                OP_BCHK: r_db <= r_depth + CW'(1);
                OP_ALN: begin
                    if (r_da > r_db) begin
                        r_ia <= r_da - r_db;
                        r_ib <= '0;
                    end else begin
                        r_ia <= '0;
                        r_ib <= r_db - r_da;
                    end
                end
                OP_CMP_STEP: begin
                    r_ia <= r_ia + CW'(1);
                    r_ib <= r_ib + CW'(1);
                end
                OP_CMP_END: begin
                    r_lim <= r_ia;
                    r_ia  <= '0;
                end
                OP_XEMIT: r_ia <= r_ia + CW'(1);
                OP_NDEC:  r_ib <= r_ib - CW'(1);
                OP_COMMIT: begin
                    r_cur       <= r_target;
                    r_cur_valid <= 1'b1;
                end
                default: r_lim <= r_lim;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out <= n_out;
        end
        case (i_ctl.op)
            OP_ACCEPT: begin
                r_item   <= i_item;
                r_walk   <= r_cur;
                r_depth  <= '0;
                r_slot   <= '0;
                r_ans    <= 1'b0;
                r_target <= i_item.state_index;
            end
            OP_QCMP: begin
                if (r_walk == r_item.state_index) begin
                    r_ans <= 1'b1;
                end
            end
            OP_UP_RD: begin
                r_walk  <= srd.parent;
                r_depth <= r_depth + CW'(1);
                r_slot  <= '0;
            end
            OP_DST: begin
                r_ent  <= srd;
                r_slot <= '0;
            end
            OP_TAKE: begin
                r_ans    <= 1'b1;
                r_target <= trd.target;
                r_tfl    <= trd.flags;
            end
            OP_NEXT_SLOT: r_slot <= r_slot + SLOT_W'(1);
            OP_UP_REG: begin
                r_walk  <= r_ent.parent;
                r_depth <= r_depth + CW'(1);
                r_slot  <= '0;
            end
            OP_GSTART: begin
                r_walk  <= (r_cur_valid && (r_cur != r_target)) ? r_cur : r_target;
                r_depth <= '0;
            end
            OP_SLATCH: begin
                r_sx <= srd.exit_f;
                r_sn <= srd.entry_f;
            end
            OP_ARD: r_src[d_idx] <= r_walk;
            OP_ACHK: begin
                r_src_x[d_idx] <= srd.exit_f;
                if (srd.has_parent && depth_ok) begin
                    r_walk  <= srd.parent;
                    r_depth <= r_depth + CW'(1);
                end else begin
                    r_walk  <= r_target;
                    r_depth <= '0;
                end
            end
            OP_BRD: r_ep[d_idx] <= r_walk;
            OP_BCHK: begin
                r_ep_n[d_idx] <= srd.entry_f;
                if (srd.has_parent && depth_ok) begin
                    r_walk  <= srd.parent;
                    r_depth <= r_depth + CW'(1);
                end
            end
            default: r_slot <= r_slot;
        endcase
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    // a new result never overwrites one still waiting downstream
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_en |-> (!r_ov || !i_stall))
        else $error("result overwritten while stalled");

    // only the finished result closes a transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.last) |-> (r_out.kind == KIND_DONE))
        else $error("last flag on non-finished result");

    // chain indexes stay inside the built chains
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ia <= r_da) && (r_ib <= r_db))
        else $error("chain index beyond chain length");

    // exits are only emitted below the common ancestor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == OP_XEMIT) |-> (r_ia < r_lim))
        else $error("exit walk past common ancestor");
endmodule

FILE: rtl/core/hierarchical_state_machine_engine_unit.sv
// top level of the hierarchical state machine engine
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_item (hsme_pkg::t_in)
//  output  | out       | o_valid / i_stall  | o_item (hsme_pkg::t_out)
//
// loads and unknown commands return straight to idle; a query compares each chain state.
// dispatch walks up from the current state, examines each slot of each state visited, emits
// an action if the taken transition has one, and finishes; each step waits on one registered
// table read. a self transition emits the target's flagged exit and entry; other state changes
// build both chains, find the common ancestor and emit flagged exits below it, then entries.
// reset is synchronous active low and leaves no state active; tables are undefined until loaded.
// a stalled output holds the sequencer in any state that must emit a result; o_stall is high while a transaction runs.
`timescale 1ns / 1ps
module hierarchical_state_machine_engine_unit #(
    parameter int MAX_DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  hsme_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output hsme_pkg::t_out o_item
);
    import hsme_pkg::*;

    t_ctl    ctl;
    t_status status;
    logic    busy;

    hsme_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_item.command),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    hsme_dp #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .i_stall  (i_stall),
        .o_status (status),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

    assign o_stall = busy;
endmodule
